// ===== design/pcdd_pkg.sv =====
// Package for the PWM capture duty decoder.
// Holds the controller state type, the command and status structs and fixed constants.
// No dependencies; imported by every module of the decoder.
package pcdd_pkg;

    // Field widths that the stream format fixes.
    localparam int CH_FIELD_W   = 2;
    localparam int TIME_FIELD_W = 32;
    localparam int DUTY_BITS    = 12;
    localparam int EVT_BITS     = 16;
    localparam int MASK_BITS    = 4;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 32;

    // Duty arithmetic constants.
    localparam logic [DUTY_BITS-1:0] FULL_SCALE       = 12'd4095;
    localparam logic [DUTY_BITS-1:0] ZERO_PERIOD_DUTY = 12'h800;
    localparam logic [MASK_BITS-1:0] MASK_RESET       = 4'd10;

    // One quotient bit per divider step; a quotient that needs more bits is out of range.
    localparam int DIV_STEPS = DUTY_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Operation codes carried in tuser.
    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic load;
        logic mul;
        logic prep;
        logic step;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bypass;
        logic out_free;
    } t_status;

endpackage

// ===== design/pwm_capture_duty_decoder_unit.sv =====
// A capture transaction is absorbed in its accept cycle, one per cycle back to back.
// A read runs from acceptance to tvalid through the product, range test, 12 divider steps
// and output load; the divider steps are skipped when the period is zero, the quotient is out
// of range or the channel does not exist. The output load waits while the output register is
// still full. The next item is accepted once the result sits in the output register. The
// 12-step divider sets the read time. Synchronous active-low reset clears all channel state,
// the event counter and the output valid flag; invert_mask resets to 10.
module pwm_capture_duty_decoder_unit #(
    parameter int CHANNELS   = 4,
    parameter int TIMER_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: channel [1:0], capture_time [33:2], zero pad [39:34]
    input  logic [pcdd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: op [0]
    input  logic [0:0]                         s_axis_tuser,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: duty_channel [1:0], duty [13:2], edge_count [29:14], zero pad [31:30]
    output logic [pcdd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // tuser: fresh [0]
    output logic [0:0]                         m_axis_tuser,
    // Configuration write channel: invert_mask.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pcdd_pkg::MASK_BITS-1:0]     i_cfg_data
);
    import pcdd_pkg::*;

    t_cmd                  w_cmd;
    t_status               w_status;
    logic [CH_FIELD_W-1:0] w_out_ch;
    logic [DUTY_BITS-1:0]  w_out_duty;
    logic                  w_out_fresh;
    logic [EVT_BITS-1:0]   w_out_cnt;

    // The mask register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    pcdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pcdd_datapath #(
        .CHANNELS   (CHANNELS),
        .TIMER_BITS (TIMER_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_channel     (s_axis_tdata[CH_FIELD_W-1:0]),
        .i_time        (s_axis_tdata[CH_FIELD_W +: TIMER_BITS]),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_channel (w_out_ch),
        .o_out_duty    (w_out_duty),
        .o_out_fresh   (w_out_fresh),
        .o_out_count   (w_out_cnt)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {2'b00, w_out_cnt, w_out_duty, w_out_ch};
    assign m_axis_tuser = w_out_fresh;

endmodule

// ===== design/pcdd_datapath.sv =====
// Datapath of the PWM capture duty decoder: channel state, product, divider, output register.
// Driven by pcdd_ctrl through t_cmd and reports through t_status.
// Depends on pcdd_pkg.
module pcdd_datapath #(
    parameter int CHANNELS   = 4,
    parameter int TIMER_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pcdd_pkg::t_cmd                     i_cmd,
    output pcdd_pkg::t_status                  o_status,
    input  logic [pcdd_pkg::CH_FIELD_W-1:0]    i_channel,
    input  logic [TIMER_BITS-1:0]              i_time,
    input  logic                               i_cfg_valid,
    input  logic [pcdd_pkg::MASK_BITS-1:0]     i_cfg_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [pcdd_pkg::CH_FIELD_W-1:0]    o_out_channel,
    output logic [pcdd_pkg::DUTY_BITS-1:0]     o_out_duty,
    output logic                               o_out_fresh,
    output logic [pcdd_pkg::EVT_BITS-1:0]      o_out_count
);
    import pcdd_pkg::*;

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W = TIMER_BITS + DUTY_BITS;

    // Per-channel capture state.
    logic                    r_expect_falling [CHANNELS];
    logic [TIMER_BITS-1:0]   r_rise           [CHANNELS];
    logic [TIMER_BITS-1:0]   r_high           [CHANNELS];
    logic [TIMER_BITS-1:0]   r_period         [CHANNELS];
    logic [DUTY_BITS-1:0]    r_held           [CHANNELS];
    logic [EVT_BITS-1:0]     r_evt_cnt;
    logic [MASK_BITS-1:0]    r_mask;

    // Operands and flags of the read in progress.
    logic [CH_FIELD_W-1:0]   r_rd_ch;
    logic [IDX_W-1:0]        r_rd_idx;
    logic                    r_ch_ok;
    logic                    r_inv;
    logic [TIMER_BITS-1:0]   r_hi;
    logic [TIMER_BITS-1:0]   r_per;
    logic [PROD_W-1:0]       r_prod;
    logic [TIMER_BITS-1:0]   r_rem;
    logic [DUTY_BITS-1:0]    r_low;
    logic [DUTY_BITS-1:0]    r_quo;
    logic                    r_zero;
    logic                    r_ovf;

    // Output register.
    logic                    r_out_valid;
    logic [CH_FIELD_W-1:0]   r_out_ch;
    logic [DUTY_BITS-1:0]    r_out_duty;
    logic                    r_out_fresh;
    logic [EVT_BITS-1:0]     r_out_cnt;

    logic [IDX_W-1:0]        w_idx;
    logic                    w_in_ok;
    logic [TIMER_BITS-1:0]   w_rem_init;
    logic                    w_zero;
    logic                    w_ovf;
    logic [TIMER_BITS:0]     w_shift;
    logic [TIMER_BITS:0]     w_diff;
    logic [DUTY_BITS-1:0]    w_q;
    logic [DUTY_BITS-1:0]    w_duty_new;
    logic                    w_fresh;
    logic                    w_out_free;

    // Channel decode of the incoming item.
    assign w_idx   = IDX_W'(i_channel);
    assign w_in_ok = (32'(i_channel) < CHANNELS);

    // Range test: the quotient reaches 4096 exactly when the upper product bits reach the period.
    assign w_rem_init = r_prod[PROD_W-1:DUTY_BITS];
    assign w_zero     = (r_per == '0);
    assign w_ovf      = !w_zero && (w_rem_init >= r_per);

    // One restoring divider step; the top bit of the difference is the borrow.
    assign w_shift = {r_rem, r_low[DUTY_BITS-1]};
    assign w_diff  = w_shift - {1'b0, r_per};

    // Result of a finished read; inversion of a 12-bit value is its complement to 4095.
    assign w_q        = r_zero ? ZERO_PERIOD_DUTY : r_quo;
    assign w_duty_new = r_inv ? (FULL_SCALE - w_q) : w_q;
    assign w_fresh    = r_ch_ok && !r_ovf;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_status.bypass   = !r_ch_ok || w_zero || w_ovf;
    assign o_status.out_free = w_out_free;

    // Capture state, event counter, held duties and the configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_expect_falling[c] <= 1'b0;
                r_rise[c]           <= '0;
                r_high[c]           <= '0;
                r_period[c]         <= '0;
                r_held[c]           <= '0;
            end
            r_evt_cnt <= '0;
            r_mask    <= MASK_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_mask <= i_cfg_data;
            end
            if (i_cmd.capture) begin
                r_evt_cnt <= r_evt_cnt + 1'b1;
                if (w_in_ok) begin
                    if (r_expect_falling[w_idx]) begin
                        r_high[w_idx]           <= i_time - r_rise[w_idx];
                        r_expect_falling[w_idx] <= 1'b0;
                    end else begin
                        r_period[w_idx]         <= i_time - r_rise[w_idx];
                        r_rise[w_idx]           <= i_time;
                        r_expect_falling[w_idx] <= 1'b1;
                    end
                end
            end
            if (i_cmd.finish && w_fresh) begin
                r_held[r_rd_idx] <= w_duty_new;
            end
        end
    end

    // Read operands, product high * 4095 as a shift and subtract, and the divider.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_ch  <= i_channel;
            r_rd_idx <= w_idx;
            r_ch_ok  <= w_in_ok;
            r_inv    <= r_mask[i_channel];
            r_hi     <= w_in_ok ? r_high[w_idx] : '0;
            r_per    <= w_in_ok ? r_period[w_idx] : '0;
        end
        if (i_cmd.mul) begin
            r_prod <= (PROD_W'(r_hi) << DUTY_BITS) - PROD_W'(r_hi);
        end
        if (i_cmd.prep) begin
            r_rem  <= w_rem_init;
            r_low  <= r_prod[DUTY_BITS-1:0];
            r_quo  <= '0;
            r_zero <= w_zero;
            r_ovf  <= w_ovf;
        end
        if (i_cmd.step) begin
            r_low <= {r_low[DUTY_BITS-2:0], 1'b0};
            if (!w_diff[TIMER_BITS]) begin
                r_rem <= w_diff[TIMER_BITS-1:0];
                r_quo <= {r_quo[DUTY_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[TIMER_BITS-1:0];
                r_quo <= {r_quo[DUTY_BITS-2:0], 1'b0};
            end
        end
    end

    // Output register: loaded when a read finishes, freed when the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_ch    <= r_rd_ch;
            r_out_fresh <= w_fresh;
            r_out_cnt   <= r_evt_cnt;
            if (w_fresh) begin
                r_out_duty <= w_duty_new;
            end else if (r_ch_ok) begin
                r_out_duty <= r_held[r_rd_idx];
            end else begin
                r_out_duty <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_ch;
    assign o_out_duty    = r_out_duty;
    assign o_out_fresh   = r_out_fresh;
    assign o_out_count   = r_out_cnt;

    // A finished read always presents a result in the next cycle.
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("finished read did not load the output register");

    // The partial remainder stays below the period throughout the division.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_rem < r_per))
        else $error("divider remainder reached the period");

    // Every capture advances the event counter by one.
    a_evt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.capture |=> (r_evt_cnt == $past(r_evt_cnt) + 16'd1))
        else $error("event counter missed a capture");

endmodule

// ===== design/pcdd_ctrl.sv =====
// Controller of the PWM capture duty decoder: sequences captures and duty reads.
// Issues t_cmd to pcdd_datapath and reads its t_status.
// Depends on pcdd_pkg.
module pcdd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_op,
    output logic                o_in_ready,
    input  pcdd_pkg::t_status   i_status,
    output pcdd_pkg::t_cmd      o_cmd
);
    import pcdd_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    // State and step counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == OP_READ) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_MUL;
                    end else begin
                        o_cmd.capture = 1'b1;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = i_status.bypass ? S_OUT : S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The step counter never runs past the quotient width.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CNT_W'(DIV_STEPS)))
        else $error("divider step counter out of range");

endmodule
